### rtl/mlrq_pkg.sv
// mlrq_pkg: shared types and constants of the multilevel ready queue scheduler
// used by mlrq_core and multilevel_ready_queue_scheduler_unit, no dependencies
package mlrq_pkg;

  localparam int MLRQ_NUM_TASKS  = 16;
  localparam int MLRQ_NUM_LEVELS = 64;

  localparam int ID_W  = 4;
  localparam int PRI_W = 6;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SCHED  = 2'd1,
    OP_SLEEP  = 2'd2,
    OP_WAKE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ABSENT  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_WAITING = 2'd3
  } st_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  task_id;
    logic [PRI_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] active_task;
    logic            running_valid;
    st_t             task_state;
    logic            op_error;
  } rsp_t;

endpackage

### rtl/mlrq_core.sv
// mlrq_core: task tables, per-level ready bitmap and the combinational
// enqueue / pop logic that updates them; depends on mlrq_pkg
module mlrq_core #(
  parameter int NUM_TASKS  = mlrq_pkg::MLRQ_NUM_TASKS,
  parameter int NUM_LEVELS = mlrq_pkg::MLRQ_NUM_LEVELS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  mlrq_pkg::req_t  req,
  output mlrq_pkg::rsp_t  rsp
);
  import mlrq_pkg::*;

  localparam int TW = $clog2(NUM_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);

  // per-task tables
  logic [LW-1:0]         level_r  [NUM_TASKS];
  logic [LW-1:0]         level_nxt[NUM_TASKS];
  st_t                   status_r [NUM_TASKS];
  st_t                   status_nxt[NUM_TASKS];
  logic [TW-1:0]         next_r   [NUM_TASKS];
  logic [TW-1:0]         next_nxt [NUM_TASKS];
  logic [NUM_TASKS-1:0]  head_r, head_nxt;
  logic [NUM_TASKS-1:0]  tail_r, tail_nxt;
  logic [NUM_LEVELS-1:0] ready_r, ready_nxt;
  logic [TW-1:0]         run_task_r, run_task_nxt;
  logic                  run_flag_r, run_flag_nxt;

  // decode stage values
  logic                  id_ok;
  logic [TW-1:0]         tid;
  logic [LW-1:0]         pri_sat;
  logic                  err;
  logic                  enq;
  logic                  pop;
  logic [TW-1:0]         enq_task;
  logic [LW-1:0]         enq_lvl;
  st_t                   st_a     [NUM_TASKS];
  logic [LW-1:0]         lvl_a    [NUM_TASKS];

  // after enqueue
  logic [NUM_TASKS-1:0]  tail_hit;
  logic [TW-1:0]         next_a   [NUM_TASKS];
  logic [NUM_TASKS-1:0]  head_a, tail_a;
  logic [NUM_LEVELS-1:0] ready_a;

  // pop selection
  logic                  any_ready;
  logic [LW-1:0]         pop_lvl;
  logic [NUM_TASKS-1:0]  head_hit;
  logic [TW-1:0]         pop_task;
  logic [TW-1:0]         pop_next;
  logic                  pop_last;

  assign id_ok   = (9'(req.task_id) < 9'(NUM_TASKS));
  assign tid     = TW'(req.task_id);
  assign pri_sat = (7'(req.priority_req) >= 7'(NUM_LEVELS)) ? LW'(NUM_LEVELS - 1)
                                                            : LW'(req.priority_req);

  always_comb begin
    st_a     = status_r;
    lvl_a    = level_r;
    err      = 1'b0;
    enq      = 1'b0;
    pop      = 1'b0;
    enq_task = tid;
    enq_lvl  = pri_sat;
    case (req.op)
      OP_CREATE: begin
        if (!id_ok || status_r[tid] == ST_READY || status_r[tid] == ST_RUNNING) begin
          err = 1'b1;
        end else begin
          enq        = 1'b1;
          lvl_a[tid] = pri_sat;
          st_a[tid]  = ST_READY;
        end
      end
      OP_SCHED: begin
        pop = 1'b1;
        // running task goes back to the tail of its level
        if (run_flag_r && status_r[run_task_r] == ST_RUNNING) begin
          enq              = 1'b1;
          enq_task         = run_task_r;
          enq_lvl          = level_r[run_task_r];
          st_a[run_task_r] = ST_READY;
        end
      end
      OP_SLEEP: begin
        if (!run_flag_r) begin
          err = 1'b1;
        end else begin
          st_a[run_task_r] = ST_WAITING;
          pop              = 1'b1;
        end
      end
      OP_WAKE: begin
        if (!id_ok || status_r[tid] != ST_WAITING) begin
          err = 1'b1;
        end else begin
          enq       = 1'b1;
          enq_lvl   = level_r[tid];
          st_a[tid] = ST_READY;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  // append: the queued task flagged as tail of the level gets linked
  always_comb begin
    next_a  = next_r;
    head_a  = head_r;
    ready_a = ready_r;
    for (int i = 0; i < NUM_TASKS; i++) begin
      tail_hit[i] = enq && (status_r[i] == ST_READY) && (level_r[i] == enq_lvl) && tail_r[i];
      if (tail_hit[i]) begin
        next_a[i] = enq_task;
      end
    end
    tail_a = tail_r & ~tail_hit;
    if (enq) begin
      tail_a[enq_task]  = 1'b1;
      head_a[enq_task]  = !ready_r[enq_lvl];
      ready_a[enq_lvl]  = 1'b1;
    end
  end

  // lowest-numbered non-empty level and its head
  always_comb begin
    any_ready = |ready_a;
    pop_lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ready_a[i]) begin
        pop_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    pop_task = '0;
    pop_next = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      head_hit[i] = pop && any_ready && (st_a[i] == ST_READY) && (lvl_a[i] == pop_lvl)
                    && head_a[i];
      if (head_hit[i]) begin
        pop_task = TW'(i);
        pop_next = next_a[i];
      end
    end
    pop_last = |(head_hit & tail_a);
  end

  always_comb begin
    level_nxt    = lvl_a;
    status_nxt   = st_a;
    next_nxt     = next_a;
    head_nxt     = head_a;
    tail_nxt     = tail_a;
    ready_nxt    = ready_a;
    run_task_nxt = run_task_r;
    run_flag_nxt = run_flag_r;
    if (pop) begin
      run_flag_nxt = any_ready;
      run_task_nxt = '0;
      if (any_ready) begin
        status_nxt[pop_task] = ST_RUNNING;
        head_nxt[pop_task]   = 1'b0;
        run_task_nxt         = pop_task;
        if (pop_last) begin
          ready_nxt[pop_lvl] = 1'b0;
        end else begin
          head_nxt[pop_next] = 1'b1;
        end
      end
    end
  end

  assign rsp.active_task   = run_flag_nxt ? ID_W'(run_task_nxt) : '0;
  assign rsp.running_valid = run_flag_nxt;
  assign rsp.task_state    = id_ok ? status_nxt[tid] : ST_ABSENT;
  assign rsp.op_error      = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        level_r[i]  <= '0;
        status_r[i] <= ST_ABSENT;
      end
      head_r     <= '0;
      tail_r     <= '0;
      ready_r    <= '0;
      run_task_r <= '0;
      run_flag_r <= 1'b0;
    end else if (go) begin
      level_r    <= level_nxt;
      status_r   <= status_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      ready_r    <= ready_nxt;
      run_task_r <= run_task_nxt;
      run_flag_r <= run_flag_nxt;
    end
  end

  // links are only followed from a queued task, so no reset
  always_ff @(posedge clk) begin
    if (go) begin
      next_r <= next_nxt;
    end
  end

endmodule

### rtl/multilevel_ready_queue_scheduler_unit.sv
// multilevel_ready_queue_scheduler_unit: top level with input register, result
// register and handshake control; instantiates mlrq_core, uses mlrq_pkg
//
// Usage:
//   in_*  : one scheduler command per transaction (create, schedule, sleep, wake)
//           with task id and priority level; accepted when in_valid && !in_stall.
//   out_* : one result per command: running task, running flag, state of the
//           addressed task after the command, and an error flag for commands
//           that were ignored; taken when out_valid && !out_stall.
//   An accepted command waits in the input register until the result register
//   is free or being taken. Throughput is one command per cycle unless a result
//   waits under out_stall; each command reads and updates the task tables and
//   ready bitmap combinationally (priority encoder over the level bitmap, then
//   a parallel match over the task table).
//   While a result waits under out_stall, one more command is taken into the
//   input register and in_stall rises only after that.
//   Synchronous reset marks every task absent, empties all levels and leaves
//   no task running; no output transaction is pending after reset.
module multilevel_ready_queue_scheduler_unit #(
  parameter int NUM_TASKS  = mlrq_pkg::MLRQ_NUM_TASKS,
  parameter int NUM_LEVELS = mlrq_pkg::MLRQ_NUM_LEVELS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_op,
  input  logic [mlrq_pkg::ID_W-1:0]    in_task_id,
  input  logic [mlrq_pkg::PRI_W-1:0]   in_priority_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mlrq_pkg::ID_W-1:0]    out_active_task,
  output logic                         out_running_valid,
  output logic [1:0]                   out_task_state,
  output logic                         out_op_error
);
  import mlrq_pkg::*;

  req_t in_r, in_nxt;
  logic in_full_r, in_full_nxt;
  rsp_t out_r;
  rsp_t rsp;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic go;
  logic in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign go       = in_full_r && advance;
  assign in_stall = in_full_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_nxt.op           = op_t'(in_op);
  assign in_nxt.task_id      = in_task_id;
  assign in_nxt.priority_req = in_priority_req;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) begin
      in_full_nxt = 1'b1;
    end else if (go) begin
      in_full_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_nxt;
    end
    if (go) begin
      out_r <= rsp;
    end
  end

  mlrq_core #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .req   (in_r),
    .rsp   (rsp)
  );

  assign out_valid         = out_valid_r;
  assign out_active_task   = out_r.active_task;
  assign out_running_valid = out_r.running_valid;
  assign out_task_state    = out_r.task_state;
  assign out_op_error      = out_r.op_error;

  // no task running means task number reads as zero
  a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_active_task == '0)
    else $error("active task nonzero while nothing runs");

  // input side only holds off while a result is stuck downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a processed command always shows up as a result next cycle
  a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid)
    else $error("processed command produced no result");

  // schedule never reports an error
  a_sched_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_r.op == OP_SCHED |=> !out_op_error)
    else $error("schedule flagged as error");

endmodule

### dv/multilevel_ready_queue_scheduler_unit_tb.sv
// testbench for multilevel_ready_queue_scheduler_unit: directed and random scheduler
// commands, checked against a queue-level model held in a small scoreboard class
// depends on mlrq_pkg and the rtl of the scheduler unit
module multilevel_ready_queue_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlrq_pkg::*;

  localparam int NTASK = MLRQ_NUM_TASKS;
  localparam int NLVL  = MLRQ_NUM_LEVELS;

  class sched_scoreboard;
    st_t              status[NTASK];
    logic [PRI_W-1:0] level[NTASK];
    logic [ID_W-1:0]  link[NTASK];
    logic [ID_W-1:0]  head[NLVL];
    logic [ID_W-1:0]  tail[NLVL];
    logic [NLVL-1:0]  ready_mask;
    logic [ID_W-1:0]  run_id;
    logic             run_on;
    rsp_t             sched_outcomes[$];
    int               failures;

    function new();
      foreach (status[i]) begin
        status[i] = ST_ABSENT;
        level[i] = '0;
        link[i] = '0;
      end
      foreach (head[i]) begin
        head[i] = '0;
        tail[i] = '0;
      end
      ready_mask = '0;
      run_id = '0;
      run_on = 1'b0;
      failures = 0;
    endfunction

    function void append_task(logic [ID_W-1:0] t);
      logic [PRI_W-1:0] lv;
      lv = level[t];
      if (!ready_mask[lv]) begin
        head[lv] = t;
      end else begin
        link[tail[lv]] = t;
      end
      tail[lv] = t;
      ready_mask[lv] = 1'b1;
    endfunction

    // requeue the running task, then pop the head of the best non-empty level
    function void dispatch();
      logic [ID_W-1:0] t;
      if (run_on && status[run_id] == ST_RUNNING) begin
        status[run_id] = ST_READY;
        append_task(run_id);
      end
      run_on = 1'b0;
      run_id = '0;
      for (int lv = 0; lv < NLVL; lv++) begin
        if (ready_mask[lv]) begin
          t = head[lv];
          if (head[lv] == tail[lv]) begin
            ready_mask[lv] = 1'b0;
          end else begin
            head[lv] = link[t];
          end
          status[t] = ST_RUNNING;
          run_id = t;
          run_on = 1'b1;
          return;
        end
      end
    endfunction

    function void record_command(op_t op, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
      rsp_t outcome;
      logic err;
      err = 1'b0;
      case (op)
        OP_CREATE: begin
          if (status[id] == ST_READY || status[id] == ST_RUNNING) begin
            err = 1'b1;
          end else begin
            level[id] = pri;
            status[id] = ST_READY;
            append_task(id);
          end
        end
        OP_SCHED: begin
          dispatch();
        end
        OP_SLEEP: begin
          if (!run_on) begin
            err = 1'b1;
          end else begin
            status[run_id] = ST_WAITING;
            dispatch();
          end
        end
        default: begin
          if (status[id] != ST_WAITING) begin
            err = 1'b1;
          end else begin
            status[id] = ST_READY;
            append_task(id);
          end
        end
      endcase
      outcome.active_task = run_on ? run_id : '0;
      outcome.running_valid = run_on;
      outcome.task_state = status[id];
      outcome.op_error = err;
      sched_outcomes.push_back(outcome);
    endfunction

    function void compare_result(logic [ID_W-1:0] cur, logic rv, logic [1:0] st, logic err);
      rsp_t want;
      if (sched_outcomes.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: active_task=%0d running_valid=%0b",
                   cur, rv, " task_state=%0d op_error=%0b", st, err);
        return;
      end
      want = sched_outcomes.pop_front();
      if (cur !== want.active_task || rv !== want.running_valid ||
          st !== want.task_state || err !== want.op_error) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: exp cur=%0d valid=%0b state=%0d err=%0b,",
                   want.active_task, want.running_valid, want.task_state, want.op_error,
                   " got cur=%0d valid=%0b state=%0d err=%0b", cur, rv, st, err);
      end
    endfunction

    function int pending();
      return sched_outcomes.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_op = '0;
  logic [ID_W-1:0]  in_task_id = '0;
  logic [PRI_W-1:0] in_priority_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ID_W-1:0]  out_active_task;
  logic             out_running_valid;
  logic [1:0]       out_task_state;
  logic             out_op_error;

  sched_scoreboard sb;
  int burst_left = 0;
  int commands_done = 0;

  multilevel_ready_queue_scheduler_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_task_id        (in_task_id),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_active_task   (out_active_task),
    .out_running_valid (out_running_valid),
    .out_task_state    (out_task_state),
    .out_op_error      (out_op_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one command and hold it until the transaction completes
  task automatic issue(op_t op, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_task_id <= id;
    in_priority_req <= pri;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.record_command(op, id, pri);
    burst_left--;
    commands_done++;
  endtask

  // waiting_only: a sleeping task; otherwise one that create would accept
  function automatic logic [ID_W-1:0] pick_task(bit waiting_only);
    logic [ID_W-1:0] cand[$];
    for (int i = 0; i < NTASK; i++) begin
      if (sb.status[i] == ST_WAITING || (!waiting_only && sb.status[i] == ST_ABSENT))
        cand.push_back(ID_W'(i));
    end
    if (cand.size() == 0) return ID_W'($urandom_range(0, NTASK - 1));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // mostly a few crowded levels so queues get several entries
  function automatic logic [PRI_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return PRI_W'($urandom_range(0, 3));
    if (r < 7) return PRI_W'($urandom_range(NLVL - 2, NLVL - 1));
    return PRI_W'($urandom_range(0, NLVL - 1));
  endfunction

  task automatic random_command();
    int r;
    logic [ID_W-1:0] id;
    logic [PRI_W-1:0] pri;
    r = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, NTASK - 1));
    pri = PRI_W'($urandom_range(0, NLVL - 1));
    if (r < 8) begin
      issue(op_t'($urandom_range(0, 3)), id, pri);
    end else if (r < 36) begin
      if ($urandom_range(0, 4) != 0) id = pick_task(1'b0);
      issue(OP_CREATE, id, pick_level());
    end else if (r < 66) begin
      issue(OP_SCHED, id, pri);
    end else if (r < 80) begin
      issue(OP_SLEEP, id, pri);
    end else begin
      if ($urandom_range(0, 6) != 0) id = pick_task(1'b1);
      issue(OP_WAKE, id, pri);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.compare_result(out_active_task, out_running_valid, out_task_state, out_op_error);
  end

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin : rx_stall
    int mode;
    int span;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= $urandom_range(0, 1);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
      if (!held && commands_done >= 300) begin
        held = 1'b1;
        repeat (200) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    int guard;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_SCHED, 4'd0, 6'd0);     // nothing ready, nothing runs
    issue(OP_SLEEP, 4'd0, 6'd0);     // sleep with no running task
    issue(OP_WAKE, 4'd5, 6'd0);      // wake of an absent task
    issue(OP_CREATE, 4'd0, 6'd63);
    issue(OP_CREATE, 4'd15, 6'd0);
    issue(OP_CREATE, 4'd15, 6'd7);   // already ready
    issue(OP_CREATE, 4'd3, 6'd0);
    issue(OP_SCHED, 4'd15, 6'd0);
    issue(OP_CREATE, 4'd15, 6'd1);   // already running
    issue(OP_SCHED, 4'd3, 6'd0);     // yield, round robin within level 0
    issue(OP_SCHED, 4'd15, 6'd0);
    issue(OP_SLEEP, 4'd15, 6'd0);
    issue(OP_WAKE, 4'd15, 6'd0);
    issue(OP_WAKE, 4'd15, 6'd0);     // already ready
    issue(OP_WAKE, 4'd3, 6'd0);      // running, not waiting
    issue(OP_SLEEP, 4'd3, 6'd0);
    issue(OP_SLEEP, 4'd15, 6'd0);
    issue(OP_CREATE, 4'd3, 6'd42);   // re-create of a waiting task
    issue(OP_SCHED, 4'd3, 6'd0);
    issue(OP_SLEEP, 4'd0, 6'd0);
    issue(OP_SLEEP, 4'd0, 6'd0);     // queue drains, nothing left to run
    issue(OP_SLEEP, 4'd0, 6'd0);
    issue(OP_WAKE, 4'd0, 6'd21);
    issue(OP_WAKE, 4'd10, 6'd0);
    issue(OP_SCHED, 4'd0, 6'd0);

    for (int k = 0; k < 600; k++) random_command();
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
